// ===== sv/ffba_pkg.sv =====
// Package for the first-fit block allocator.
// Holds the request and response structs and the operation and status codes.
// No dependencies.
package ffba_pkg;

  localparam int SIZE_W   = 13;
  localparam int HANDLE_W = 12;
  localparam int OFFSET_W = 12;
  localparam int COUNT_W  = 4;
  localparam int DATA_W   = 64;

  typedef enum logic [1:0] {
    OP_ALLOC = 2'd0,
    OP_FREE  = 2'd1,
    OP_WRITE = 2'd2,
    OP_READ  = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK            = 2'd0,
    ST_NOT_FOUND     = 2'd1,
    ST_OUT_OF_BOUNDS = 2'd2,
    ST_NO_SPACE      = 2'd3
  } status_t;

  typedef struct packed {
    opcode_t               opcode;
    logic [SIZE_W-1:0]     alloc_size;
    logic [HANDLE_W-1:0]   handle;
    logic [OFFSET_W-1:0]   byte_offset;
    logic [COUNT_W-1:0]    byte_count;
    logic [DATA_W-1:0]     write_data;
  } req_t;

  typedef struct packed {
    status_t               status;
    logic [HANDLE_W-1:0]   base_address;
    logic [DATA_W-1:0]     read_bytes;
  } rsp_t;

endpackage

// ===== sv/ffba_table.sv =====
// Block table: base and size memory with one registered read port, plus in-use flags.
// The in-use flags are flip-flops cleared by reset; base and size are undefined until written.
// Depends on ffba_pkg.
module ffba_table
  import ffba_pkg::*;
#(
  parameter int MAX_BLOCKS = 64,
  parameter int BASE_W     = 12
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [$clog2(MAX_BLOCKS)-1:0] rd_idx,
  output logic [BASE_W-1:0]             q_base,
  output logic [SIZE_W-1:0]             q_size,
  output logic                          q_used,
  input  logic                          wr_en,
  input  logic [$clog2(MAX_BLOCKS)-1:0] wr_idx,
  input  logic [BASE_W-1:0]             wr_base,
  input  logic [SIZE_W-1:0]             wr_size,
  input  logic                          set_used,
  input  logic                          clr_used,
  input  logic [$clog2(MAX_BLOCKS)-1:0] mark_idx
);

  logic [BASE_W+SIZE_W-1:0] mem [MAX_BLOCKS];
  logic [MAX_BLOCKS-1:0]    in_use;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_idx] <= {wr_base, wr_size};
    end
    {q_base, q_size} <= mem[rd_idx];
    q_used <= in_use[rd_idx];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_use <= '0;
    end else if (wr_en) begin
      in_use[wr_idx] <= 1'b1;
    end else if (set_used) begin
      in_use[mark_idx] <= 1'b1;
    end else if (clr_used) begin
      in_use[mark_idx] <= 1'b0;
    end
  end

endmodule

// ===== sv/ffba_heap.sv =====
// Byte heap: single-port byte memory with a registered read.
// Contents are undefined until written.
// No dependencies.
module ffba_heap #(
  parameter int HEAP_SIZE = 4096
) (
  input  logic                         clk,
  input  logic [$clog2(HEAP_SIZE)-1:0] addr,
  input  logic                         we,
  input  logic [7:0]                   wdata,
  output logic [7:0]                   q
);

  logic [7:0] mem [HEAP_SIZE];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    q <= mem[addr];
  end

endmodule

// ===== sv/first_fit_block_allocator.sv =====
// First-fit block allocator: sequencer, table scan compare unit and byte mover.
// Depends on ffba_pkg, ffba_table and ffba_heap.
//
//   channel   | handshake          | payload
//   ----------+--------------------+--------
//   request   | start, busy        | req
//   result    | done (one cycle)   | rsp
//
// The table scan reads one entry per cycle through the table memory port.
// A write or a read then moves one byte per cycle through the heap.
// Reset clears the in-use flags, the block count and the bump pointer at once.
// The result is shown for one cycle with done, and busy is low in that cycle, so the next
// request can be accepted then. The receiver cannot stall, so results never wait.
module first_fit_block_allocator
  import ffba_pkg::*;
#(
  parameter int MAX_BLOCKS       = 64,
  parameter int HEAP_SIZE        = 4096,
  parameter int MAX_ACCESS_BYTES = 8
) (
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  input  req_t req,
  output logic done,
  output rsp_t rsp
);

  localparam int AW   = $clog2(HEAP_SIZE);
  localparam int NW   = $clog2(HEAP_SIZE + 1);
  localparam int IW   = $clog2(MAX_BLOCKS);
  localparam int CNTW = $clog2(MAX_BLOCKS + 1);
  localparam int CMPW = (AW > HANDLE_W) ? AW : HANDLE_W;
  localparam int ADW  = CMPW + 1;
  localparam int SUMW = ((NW > SIZE_W) ? NW : SIZE_W) + 1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_BYTES
  } state_t;

  state_t              state;
  req_t                req_r;
  logic [CNTW-1:0]     issue_idx;
  logic                cmp_valid;
  logic [IW-1:0]       cmp_idx;
  logic [CNTW-1:0]     block_count;
  logic [NW-1:0]       next_free_address;
  logic [ADW-1:0]      addr_r;
  logic [COUNT_W-1:0]  bi;
  logic                pend;
  logic                pend_ok;
  logic [DATA_W-1:0]   rdata;

  logic [AW-1:0]       q_base;
  logic [SIZE_W-1:0]   q_size;
  logic                q_used;
  logic [7:0]          heap_q;

  logic                hit;
  logic                miss;
  logic                is_alloc;
  logic                table_full;
  logic [SUMW-1:0]     end_addr;
  logic                out_of_bounds;
  logic [ADW-1:0]      byte_addr;
  logic                in_range;
  logic [2:0]          byte_sel;
  logic                tbl_wr;
  logic                set_used;
  logic                clr_used;
  logic                heap_we;

  assign is_alloc = (req_r.opcode == OP_ALLOC);

  always_comb begin
    hit = 1'b0;
    if (cmp_valid) begin
      if (is_alloc) begin
        hit = !q_used && (q_size >= req_r.alloc_size);
      end else begin
        hit = (CMPW'(q_base) == CMPW'(req_r.handle));
      end
    end
  end

  assign miss = !cmp_valid && (issue_idx >= block_count);

  assign end_addr   = SUMW'(next_free_address) + SUMW'(req_r.alloc_size);
  assign table_full = (block_count >= CNTW'(MAX_BLOCKS)) ||
                      (next_free_address >= NW'(HEAP_SIZE)) ||
                      (end_addr > SUMW'(HEAP_SIZE));

  assign out_of_bounds = (req_r.byte_count > COUNT_W'(MAX_ACCESS_BYTES)) ||
                         (SIZE_W'(req_r.byte_offset) + SIZE_W'(req_r.byte_count) > q_size);

  assign byte_addr = addr_r + ADW'(bi) - ADW'(1);
  assign in_range  = (byte_addr < ADW'(HEAP_SIZE));
  assign byte_sel  = 3'(bi - COUNT_W'(1));

  assign tbl_wr   = (state == S_SCAN) && miss && is_alloc && !table_full;
  assign set_used = (state == S_SCAN) && hit && is_alloc;
  assign clr_used = (state == S_SCAN) && hit && (req_r.opcode == OP_FREE);
  assign heap_we  = (state == S_BYTES) && (bi != '0) &&
                    (req_r.opcode == OP_WRITE) && in_range;

  assign busy = (state != S_IDLE);

  ffba_table #(
    .MAX_BLOCKS (MAX_BLOCKS),
    .BASE_W     (AW)
  ) u_table (
    .clk      (clk),
    .rst      (rst),
    .rd_idx   (issue_idx[IW-1:0]),
    .q_base   (q_base),
    .q_size   (q_size),
    .q_used   (q_used),
    .wr_en    (tbl_wr),
    .wr_idx   (block_count[IW-1:0]),
    .wr_base  (next_free_address[AW-1:0]),
    .wr_size  (req_r.alloc_size),
    .set_used (set_used),
    .clr_used (clr_used),
    .mark_idx (cmp_idx)
  );

  ffba_heap #(
    .HEAP_SIZE (HEAP_SIZE)
  ) u_heap (
    .clk   (clk),
    .addr  (byte_addr[AW-1:0]),
    .we    (heap_we),
    .wdata (8'(req_r.write_data >> {byte_sel, 3'b000})),
    .q     (heap_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= S_IDLE;
      block_count       <= '0;
      next_free_address <= '0;
      done              <= 1'b0;
      cmp_valid         <= 1'b0;
      pend              <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            req_r     <= req;
            issue_idx <= '0;
            cmp_valid <= 1'b0;
            pend      <= 1'b0;
            rdata     <= '0;
            state     <= S_SCAN;
          end
        end
        S_SCAN: begin
          priority if (hit) begin
            rsp.base_address <= '0;
            rsp.read_bytes   <= '0;
            rsp.status       <= ST_OK;
            unique case (req_r.opcode)
              OP_ALLOC: begin
                rsp.base_address <= HANDLE_W'(q_base);
                done             <= 1'b1;
                state            <= S_IDLE;
              end
              OP_FREE: begin
                done  <= 1'b1;
                state <= S_IDLE;
              end
              OP_WRITE, OP_READ: begin
                if (out_of_bounds) begin
                  rsp.status <= ST_OUT_OF_BOUNDS;
                  done       <= 1'b1;
                  state      <= S_IDLE;
                end else begin
                  addr_r <= ADW'(q_base) + ADW'(req_r.byte_offset);
                  bi     <= req_r.byte_count;
                  state  <= S_BYTES;
                end
              end
              default: begin
                state <= S_IDLE;
              end
            endcase
          end else if (miss) begin
            rsp.base_address <= '0;
            rsp.read_bytes   <= '0;
            done             <= 1'b1;
            state            <= S_IDLE;
            if (!is_alloc) begin
              rsp.status <= ST_NOT_FOUND;
            end else if (table_full) begin
              rsp.status <= ST_NO_SPACE;
            end else begin
              rsp.status        <= ST_OK;
              rsp.base_address  <= HANDLE_W'(next_free_address);
              block_count       <= block_count + CNTW'(1);
              next_free_address <= NW'(end_addr);
            end
          end else begin
            cmp_valid <= (issue_idx < block_count);
            cmp_idx   <= issue_idx[IW-1:0];
            if (issue_idx < block_count) begin
              issue_idx <= issue_idx + CNTW'(1);
            end
          end
        end
        S_BYTES: begin
          if (pend) begin
            rdata <= {rdata[DATA_W-9:0], pend_ok ? heap_q : 8'h00};
          end
          pend    <= (bi != '0) && (req_r.opcode == OP_READ);
          pend_ok <= in_range;
          if (bi != '0) begin
            bi <= bi - COUNT_W'(1);
          end else if (!pend) begin
            rsp.status     <= ST_OK;
            rsp.read_bytes <= (req_r.opcode == OP_READ) ? rdata : '0;
            done           <= 1'b1;
            state          <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (rst) done |-> $past(busy))
    else $error("Result strobe without a request in progress.");

  assert property (@(posedge clk) disable iff (rst) (start && !busy) |=> busy)
    else $error("Accepted request did not start the sequencer.");

  assert property (@(posedge clk) disable iff (rst)
    (done && rsp.status != ST_OK) |-> (rsp.base_address == '0 && rsp.read_bytes == '0))
    else $error("Failed request returned nonzero data.");

  assert property (@(posedge clk) disable iff (rst)
    (block_count <= CNTW'(MAX_BLOCKS)) && (next_free_address <= NW'(HEAP_SIZE)))
    else $error("Block count or bump pointer past its limit.");

  assert property (@(posedge clk) disable iff (rst) (tbl_wr || set_used) |-> !clr_used)
    else $error("Conflicting in-use updates.");

endmodule

// ===== verif/first_fit_block_allocator_tb.sv =====
// Self-checking testbench for first_fit_block_allocator.
// Depends on ffba_pkg and the allocator RTL. It runs a directed list, then random
// traffic, and checks every result against a predictor kept in a scoreboard class.
module first_fit_block_allocator_tb;
  import ffba_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_BLOCKS       = 64;
  localparam int HEAP_SIZE        = 4096;
  localparam int MAX_ACCESS_BYTES = 8;
  localparam int RANDOM_ITEMS     = 830;
  localparam int DRAIN_CYCLES     = 100;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  req_t req = '0;
  logic done;
  rsp_t rsp;

  class allocator_scoreboard;
    logic [HANDLE_W-1:0] blk_base[MAX_BLOCKS];
    logic [SIZE_W-1:0]   blk_size[MAX_BLOCKS];
    bit                  blk_used[MAX_BLOCKS];
    int                  blk_count;
    int                  bump;
    logic [7:0]          heap_mem[HEAP_SIZE];
    bit                  heap_set[HEAP_SIZE];
    rsp_t                pending_responses[$];
    int                  errors;
    int                  checked;
    int                  op_seen[4];
    int                  status_seen[4];

    function new();
      blk_count = 0;
      bump = 0;
      errors = 0;
      checked = 0;
      foreach (blk_used[i]) blk_used[i] = 1'b0;
      foreach (heap_set[i]) heap_set[i] = 1'b0;
      foreach (op_seen[i]) op_seen[i] = 0;
      foreach (status_seen[i]) status_seen[i] = 0;
    endfunction

    function int find_block(logic [HANDLE_W-1:0] h);
      int i;
      for (i = 0; i < blk_count; i++) begin
        if (blk_base[i] == h) return i;
      end
      return -1;
    endfunction

    function bit access_fits(req_t r, int k);
      return int'(r.byte_count) <= MAX_ACCESS_BYTES &&
             int'(r.byte_offset) + int'(r.byte_count) <= int'(blk_size[k]);
    endfunction

    // A read that would succeed must only touch bytes written since reset.
    function bit read_is_safe(req_t r);
      int k;
      int i;
      int addr;
      if (r.opcode != OP_READ) return 1'b1;
      k = find_block(r.handle);
      if (k < 0 || !access_fits(r, k)) return 1'b1;
      addr = int'(blk_base[k]) + int'(r.byte_offset);
      for (i = 0; i < int'(r.byte_count); i++) begin
        if (addr + i < HEAP_SIZE && !heap_set[addr + i]) return 1'b0;
      end
      return 1'b1;
    endfunction

    function rsp_t predict_response(req_t r);
      rsp_t p;
      int k;
      int i;
      int addr;
      p.status = ST_OK;
      p.base_address = '0;
      p.read_bytes = '0;
      case (r.opcode)
        OP_ALLOC: begin
          k = -1;
          for (i = 0; i < blk_count; i++) begin
            if (k < 0 && !blk_used[i] && blk_size[i] >= r.alloc_size) k = i;
          end
          if (k >= 0) begin
            blk_used[k] = 1'b1;
            p.base_address = blk_base[k];
          end else if (blk_count >= MAX_BLOCKS || bump >= HEAP_SIZE ||
                       bump + int'(r.alloc_size) > HEAP_SIZE) begin
            p.status = ST_NO_SPACE;
          end else begin
            blk_base[blk_count] = bump[HANDLE_W-1:0];
            blk_size[blk_count] = r.alloc_size;
            blk_used[blk_count] = 1'b1;
            blk_count++;
            p.base_address = bump[HANDLE_W-1:0];
            bump += int'(r.alloc_size);
          end
        end
        OP_FREE: begin
          k = find_block(r.handle);
          if (k < 0) p.status = ST_NOT_FOUND;
          else blk_used[k] = 1'b0;
        end
        default: begin
          k = find_block(r.handle);
          if (k < 0) begin
            p.status = ST_NOT_FOUND;
          end else if (!access_fits(r, k)) begin
            p.status = ST_OUT_OF_BOUNDS;
          end else begin
            addr = int'(blk_base[k]) + int'(r.byte_offset);
            for (i = 0; i < int'(r.byte_count); i++) begin
              if (addr + i < HEAP_SIZE) begin
                if (r.opcode == OP_WRITE) begin
                  heap_mem[addr + i] = r.write_data[8*i +: 8];
                  heap_set[addr + i] = 1'b1;
                end else begin
                  p.read_bytes[8*i +: 8] = heap_mem[addr + i];
                end
              end
            end
          end
        end
      endcase
      return p;
    endfunction

    function void note_request(req_t r);
      rsp_t p;
      p = predict_response(r);
      op_seen[r.opcode]++;
      status_seen[p.status]++;
      pending_responses.push_back(p);
    endfunction

    function void check_response(rsp_t got);
      rsp_t want;
      if (pending_responses.size() == 0) begin
        errors++;
        $display("%0t: result with nothing expected: status %0d base %h data %h",
                 $time, got.status, got.base_address, got.read_bytes);
        return;
      end
      want = pending_responses.pop_front();
      checked++;
      if (got.status !== want.status) begin
        errors++;
        $display("%0t: status mismatch, expected %0d, actual %0d",
                 $time, want.status, got.status);
      end
      if (got.base_address !== want.base_address) begin
        errors++;
        $display("%0t: base_address mismatch, expected %h, actual %h",
                 $time, want.base_address, got.base_address);
      end
      if (got.read_bytes !== want.read_bytes) begin
        errors++;
        $display("%0t: read_bytes mismatch, expected %h, actual %h",
                 $time, want.read_bytes, got.read_bytes);
      end
    endfunction
  endclass

  allocator_scoreboard sb = new();

  first_fit_block_allocator #(
    .MAX_BLOCKS      (MAX_BLOCKS),
    .HEAP_SIZE       (HEAP_SIZE),
    .MAX_ACCESS_BYTES(MAX_ACCESS_BYTES)
  ) i_dut (
    .clk  (clk),
    .rst  (rst),
    .start(start),
    .busy (busy),
    .req  (req),
    .done (done),
    .rsp  (rsp)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (!rst && done === 1'b1) sb.check_response(rsp);
  end

  initial begin
    #7ms;
    $display("Timeout waiting for the allocator to finish.");
    $display("first_fit_block_allocator test failed");
    $finish;
  end

  function automatic req_t make_req(opcode_t op, int unsigned size, int unsigned h,
                                    int unsigned off, int unsigned cnt,
                                    logic [DATA_W-1:0] data);
    req_t r;
    r.opcode = op;
    r.alloc_size = size[SIZE_W-1:0];
    r.handle = h[HANDLE_W-1:0];
    r.byte_offset = off[OFFSET_W-1:0];
    r.byte_count = cnt[COUNT_W-1:0];
    r.write_data = data;
    return r;
  endfunction

  function automatic req_t random_request();
    req_t r;
    int unsigned pick;
    int k;
    int bsize;
    r.alloc_size = SIZE_W'($urandom);
    r.handle = HANDLE_W'($urandom);
    r.byte_offset = OFFSET_W'($urandom);
    r.byte_count = COUNT_W'($urandom);
    r.write_data = {$urandom, $urandom};
    pick = $urandom_range(99);
    if (pick < 25) begin
      r.opcode = OP_ALLOC;
      pick = $urandom_range(31);
      if (pick == 0) r.alloc_size = '0;
      else if (pick == 1) r.alloc_size = SIZE_W'($urandom);
      else if (pick < 4) r.alloc_size = SIZE_W'($urandom_range(256, 1024));
      else r.alloc_size = SIZE_W'($urandom_range(1, 48));
    end else begin
      if (pick < 37) r.opcode = OP_FREE;
      else if (pick < 70) r.opcode = OP_WRITE;
      else r.opcode = OP_READ;
      if (sb.blk_count > 0 && $urandom_range(9) != 0) begin
        k = int'($urandom_range(sb.blk_count - 1));
        r.handle = sb.blk_base[k];
        bsize = int'(sb.blk_size[k]);
        if ($urandom_range(9) != 0) begin
          if ($urandom_range(15) == 0) r.byte_count = COUNT_W'($urandom_range(9, 15));
          else r.byte_count = COUNT_W'($urandom_range(0, MAX_ACCESS_BYTES));
          if ($urandom_range(3) == 0) r.byte_offset = OFFSET_W'($urandom_range(0, bsize));
          else if (bsize >= int'(r.byte_count))
            r.byte_offset = OFFSET_W'($urandom_range(0, bsize - int'(r.byte_count)));
          else r.byte_offset = '0;
        end
      end
      if (!sb.read_is_safe(r)) r.opcode = OP_WRITE;
    end
    return r;
  endfunction

  task automatic send_request(req_t r, int gap);
    start <= 1'b1;
    req <= r;
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.note_request(r);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  function automatic int idle_gap(bit quiet);
    if (quiet || $urandom_range(99) >= 27) return 0;
    return $urandom_range(1, 80);
  endfunction

  initial begin
    req_t directed[$];
    int n;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    directed.push_back(make_req(OP_READ,  0, 0,     0,    1, '0));
    directed.push_back(make_req(OP_FREE,  0, 12'hFFF, 0,  1, '0));
    directed.push_back(make_req(OP_ALLOC, 16, 0,    0,    0, '0));
    directed.push_back(make_req(OP_ALLOC, 8191, 0,  0,    0, '0));
    directed.push_back(make_req(OP_WRITE, 0, 0,     0,    8, '1));
    directed.push_back(make_req(OP_WRITE, 0, 0,     8,    8, 64'h0123_4567_89ab_cdef));
    directed.push_back(make_req(OP_READ,  0, 0,     0,    8, '0));
    directed.push_back(make_req(OP_READ,  0, 0,     8,    8, '0));
    directed.push_back(make_req(OP_READ,  0, 0,     15,   1, '0));
    directed.push_back(make_req(OP_READ,  0, 0,     9,    8, '0));
    directed.push_back(make_req(OP_WRITE, 0, 0,     0,    9, '1));
    directed.push_back(make_req(OP_READ,  0, 0,     0,    15, '0));
    directed.push_back(make_req(OP_WRITE, 0, 0,     4095, 8, '1));
    directed.push_back(make_req(OP_READ,  0, 0,     3,    0, '0));
    directed.push_back(make_req(OP_WRITE, 0, 0,     16,   0, '1));
    directed.push_back(make_req(OP_ALLOC, 0, 0,     0,    0, '0));
    directed.push_back(make_req(OP_ALLOC, 32, 0,    0,    0, '0));
    directed.push_back(make_req(OP_WRITE, 0, 16,    0,    1, '1));
    directed.push_back(make_req(OP_FREE,  0, 16,    0,    0, '0));
    directed.push_back(make_req(OP_ALLOC, 0, 0,     0,    0, '0));
    directed.push_back(make_req(OP_FREE,  0, 0,     0,    0, '0));
    directed.push_back(make_req(OP_ALLOC, 20, 0,    0,    0, '0));
    directed.push_back(make_req(OP_ALLOC, 4, 0,     0,    0, '0));
    directed.push_back(make_req(OP_READ,  0, 0,     4,    4, '0));
    directed.push_back(make_req(OP_FREE,  0, 0,     0,    0, '0));
    directed.push_back(make_req(OP_FREE,  0, 0,     0,    0, '0));

    foreach (directed[i]) send_request(directed[i], idle_gap(1'b0));
    for (n = 0; n < RANDOM_ITEMS; n++) begin
      send_request(random_request(), idle_gap(n >= 300 && n < 450));
    end
    send_request(make_req(OP_ALLOC, 4096, 0, 0, 0, '0), idle_gap(1'b0));
    send_request(make_req(OP_ALLOC, 1, 0, 0, 0, '0), 0);
    start <= 1'b0;

    while (sb.pending_responses.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Checked %0d results: %0d allocates, %0d frees, %0d writes, %0d reads.",
             sb.checked, sb.op_seen[OP_ALLOC], sb.op_seen[OP_FREE],
             sb.op_seen[OP_WRITE], sb.op_seen[OP_READ]);
    $display("Statuses ok/not found/out of bounds/no space: %0d/%0d/%0d/%0d; %0d blocks.",
             sb.status_seen[ST_OK], sb.status_seen[ST_NOT_FOUND],
             sb.status_seen[ST_OUT_OF_BOUNDS], sb.status_seen[ST_NO_SPACE], sb.blk_count);
    if (sb.errors == 0) begin
      $display("first_fit_block_allocator test passed");
    end else begin
      $display("first_fit_block_allocator test failed");
    end
    $finish;
  end

endmodule
